/* sv/tfhm_pkg.sv */
// Shared types, constants and the color helper for the thermal heatmap colormap block.
// Used by tfhm_div and thermal_frame_heatmap_colormap_top; no dependencies.
package tfhm_pkg;

  // Frame geometry and sample format
  localparam int FRAME_PIXELS = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int IDX_W        = 10;
  localparam int COLOR_W      = 8;

  // Divider sizing: quotient of 510*d/range stays below 512 when d < range
  localparam int Q_W   = 9;
  localparam int CNT_W = $clog2(Q_W);
  localparam int NUM_W = SAMPLE_BITS + Q_W;
  localparam int SPAN  = 510;

  localparam logic [COLOR_W-1:0] COLOR_MAX  = '1;
  localparam logic [COLOR_W-1:0] COLOR_ZERO = '0;

  // Action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV
  } tfhm_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
  } tfhm_color_t;

  // Request from the sequencer to the normalizing divider
  typedef struct packed {
    logic    start;
    sample_t smp;
    sample_t fmin;
    sample_t fmax;
  } tfhm_div_req_t;

  // Divider status: valid holds from completion until the next start
  typedef struct packed {
    logic        valid;
    tfhm_color_t color;
  } tfhm_div_sts_t;

  // Turn floor quotient and remainder flag into red/green
  function automatic tfhm_color_t tfhm_color(input logic [Q_W-1:0] q, input logic rem_nz);
    logic [Q_W:0] qc;
    logic [Q_W:0] diff;
    tfhm_color_t  c;
    qc   = {1'b0, q} + (Q_W+1)'(rem_nz);
    diff = (Q_W+1)'(SPAN) - qc;
    c.red   = (q > Q_W'(COLOR_MAX)) ? COLOR_MAX : q[COLOR_W-1:0];
    c.green = (qc <= (Q_W+1)'(COLOR_MAX)) ? COLOR_MAX : diff[COLOR_W-1:0];
    return c;
  endfunction

endpackage

/* sv/tfhm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tfhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/tfhm_div.sv */
// Normalizing divider: computes 510*(sample-min)/(max-min) by restoring division
// and converts it to red/green. Depends on tfhm_pkg.
module tfhm_div
  import tfhm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tfhm_div_req_t req,
  output tfhm_div_sts_t sts
);

  logic signed [SAMPLE_BITS:0] d;
  logic signed [SAMPLE_BITS:0] rng;
  logic                        flat_or_low;
  logic                        at_or_above;
  logic [NUM_W-1:0]            num;
  logic [NUM_W-1:0]            dvs_init;

  logic                        busy_r;
  logic                        valid_r;
  logic [NUM_W-1:0]            rem_r;
  logic [NUM_W-1:0]            dvs_r;
  logic [Q_W-1:0]              q_r;
  logic [CNT_W-1:0]            cnt_r;
  tfhm_color_t                 color_r;

  logic                        ge;
  logic [NUM_W-1:0]            rem_nxt;
  logic [Q_W-1:0]              q_nxt;

  // Offset, span and the operands of the division
  always_comb begin
    d   = {req.smp[SAMPLE_BITS-1], req.smp} - {req.fmin[SAMPLE_BITS-1], req.fmin};
    rng = {req.fmax[SAMPLE_BITS-1], req.fmax} - {req.fmin[SAMPLE_BITS-1], req.fmin};
    // empty span or sample under the minimum: coldest color
    flat_or_low = rng[SAMPLE_BITS] || (rng == '0) || d[SAMPLE_BITS];
    // sample at or over the maximum: hottest color
    at_or_above = (d >= rng);
    // 510*d as shift and subtract
    num      = {d[SAMPLE_BITS-1:0], Q_W'(0)} - NUM_W'({d[SAMPLE_BITS-1:0], 1'b0});
    dvs_init = NUM_W'({rng[SAMPLE_BITS-1:0], (Q_W-1)'(0)});
  end

  // One restoring step per cycle
  always_comb begin
    ge      = (rem_r >= dvs_r);
    rem_nxt = ge ? (rem_r - dvs_r) : rem_r;
    q_nxt   = {q_r[Q_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (req.start) begin
      busy_r  <= !(flat_or_low || at_or_above);
      valid_r <= flat_or_low || at_or_above;
      cnt_r   <= CNT_W'(Q_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= num;
      dvs_r <= dvs_init;
      q_r   <= '0;
      if (flat_or_low) begin
        color_r <= '{red: COLOR_ZERO, green: COLOR_MAX};
      end else if (at_or_above) begin
        color_r <= '{red: COLOR_MAX, green: COLOR_ZERO};
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_r >> 1;
      q_r   <= q_nxt;
      if (cnt_r == '0) begin
        color_r <= tfhm_color(q_nxt, rem_nxt != '0);
      end
    end
  end

  assign sts.valid = valid_r;
  assign sts.color = color_r;

  // Busy and done never overlap
  a_busy_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !valid_r)
    else $error("divider busy while result valid");

  // A start either finishes at once or begins iterating
  a_start_moves: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (busy_r || valid_r))
    else $error("divider start had no effect");

  // Remainder stays below twice the shifted divisor while iterating
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, rem_r} < {dvs_r, 1'b0}))
    else $error("division remainder out of bound");

endmodule

/* sv/thermal_frame_heatmap_colormap_top.sv */
// Top level of the thermal heatmap colormap: frame store RAM, min/max tracking,
// sequencer and output register. Depends on tfhm_pkg, tfhm_ram and tfhm_div.
//
// Usage:
//   Input channel (in_valid/in_ready): in_action selects a load (store
//   in_sample at in_pixel_index and update the frame min/max; an index 0 load
//   restarts both) or a map (read the stored pixel and color it).
//   Output channel (out_valid/out_ready): one beat per map with out_index,
//   out_red and out_green; loads produce no beat.
//   Timing: loads stream at one per cycle while no map is in flight.
//   A map goes through the frame store read, the divider start and nine
//   restoring division steps before its beat shows, and the next item is
//   taken only once that beat is loaded. Flat frames and out-of-span pixels
//   skip the division steps. The division loop sets the map rate.
//   The output register holds a finished beat, so the next item is accepted
//   while a result waits; a following map waits in its last step until the
//   register is free.
//   Reset: min and max clear to zero and the channels go idle; the frame store
//   is not cleared, and mapping a pixel never loaded gives an arbitrary color.
module thermal_frame_heatmap_colormap_top
  import tfhm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [IDX_W-1:0]   in_pixel_index,
  input  sample_t            in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   out_index,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green
);

  tfhm_state_t        state_r;
  tfhm_state_t        state_nxt;
  sample_t            frame_min_r;
  sample_t            frame_max_r;
  logic [IDX_W-1:0]   idx_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_index_r;
  tfhm_color_t        out_color_r;

  logic               in_acc;
  logic               in_range;
  logic               do_load;
  logic               do_map;
  logic               slot_free;
  logic               load_out;
  sample_t            smp_in;
  logic [ADDR_W-1:0]  addr;
  sample_t            rd_smp;
  tfhm_div_req_t      div_req;
  tfhm_div_sts_t      div_sts;

  // Input decode
  always_comb begin
    in_acc    = in_valid && in_ready;
    in_range  = (int'(in_pixel_index) < FRAME_PIXELS);
    do_load   = in_acc && in_range && (in_action == ACT_LOAD);
    do_map    = in_acc && in_range && (in_action == ACT_MAP);
    smp_in    = sample_t'($unsigned(in_sample));
    addr      = ADDR_W'(in_pixel_index);
    slot_free = !out_valid_r || out_ready;
  end

  // Frame store
  tfhm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (FRAME_PIXELS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (addr),
    .wdata (smp_in),
    .re    (do_map),
    .raddr (addr),
    .rdata (rd_smp)
  );

  // Normalizing divider, started while the read data is on the RAM port
  always_comb begin
    div_req.start = (state_r == S_READ);
    div_req.smp   = rd_smp;
    div_req.fmin  = frame_min_r;
    div_req.fmax  = frame_max_r;
  end

  tfhm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and outputs
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (do_map) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_sts.valid && slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Running frame min/max
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_min_r <= '0;
      frame_max_r <= '0;
    end else if (do_load) begin
      if (in_pixel_index == '0) begin
        frame_min_r <= smp_in;
        frame_max_r <= smp_in;
      end else begin
        if (smp_in < frame_min_r) begin
          frame_min_r <= smp_in;
        end
        if (smp_in > frame_max_r) begin
          frame_max_r <= smp_in;
        end
      end
    end
  end

  // Index of the map in flight
  always_ff @(posedge clk) begin
    if (do_map) begin
      idx_r <= in_pixel_index;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index_r <= idx_r;
      out_color_r <= div_sts.color;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_red   = out_color_r.red;
  assign out_green = out_color_r.green;

  // Frame min never exceeds frame max
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    frame_min_r <= frame_max_r)
    else $error("frame min above frame max");

  // A load leaves the sequencer idle
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    do_load |=> (state_r == S_IDLE))
    else $error("load left the sequencer busy");

  // A map always goes read then divide
  a_map_reads: assert property (@(posedge clk) disable iff (!rst_n)
    do_map |=> (state_r == S_READ) ##1 (state_r == S_DIV))
    else $error("map did not read the frame store");

  // Min/max hold steady while a map is in flight
  a_minmax_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ($stable(frame_min_r) && $stable(frame_max_r)))
    else $error("frame min/max changed during a map");

endmodule
